@@ hdl/pbt_pkg.sv @@
// Shared types and constants of the poly-Bezier tessellator.
package pbt_pkg;

  // Fixed-point widths.
  localparam int unsigned CoordW  = 32;
  localparam int unsigned WeightW = 17;  // Q0.16 plus a bit for 1.0
  localparam int unsigned AccW    = 52;  // four 17x32 signed products summed

  // One classified anchor word, passed from the front part to the back part.
  typedef struct packed {
    logic                     emit_self;
    logic signed [CoordW-1:0] p0_x;
    logic signed [CoordW-1:0] p0_y;
    logic signed [CoordW-1:0] p1_x;
    logic signed [CoordW-1:0] p1_y;
    logic signed [CoordW-1:0] p2_x;
    logic signed [CoordW-1:0] p2_y;
    logic signed [CoordW-1:0] p3_x;
    logic signed [CoordW-1:0] p3_y;
  } seg_cmd_t;

  // One finished point.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     last;
  } point_t;

  // Round a 50-bit product to Q0.16, halves up.
  function automatic logic [WeightW-1:0] round32(input logic [49:0] v);
    logic [50:0] s;
    s = {1'b0, v} + 51'h0_8000_0000;
    return s[48:32];
  endfunction

  // Bernstein weight k at parameter t (Q0.16, 65536 is 1.0).
  function automatic logic [WeightW-1:0] bern_weight(input logic [16:0] t, input int k);
    logic [16:0] u;
    logic [49:0] p;
    u = 17'd65536 - t;
    unique case (k)
      0:       p = 50'(u) * 50'(u) * 50'(u);
      1:       p = 50'(3) * 50'(u) * 50'(u) * 50'(t);
      2:       p = 50'(3) * 50'(u) * 50'(t) * 50'(t);
      default: p = 50'(t) * 50'(t) * 50'(t);
    endcase
    return round32(p);
  endfunction

endpackage

@@ hdl/pbt_front.sv @@
// Front part: holds the previous anchor and classifies each incoming anchor.
module pbt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 curve_start,
  input  logic signed [31:0]   anchor_x,
  input  logic signed [31:0]   anchor_y,
  input  logic signed [31:0]   left_handle_x,
  input  logic signed [31:0]   left_handle_y,
  input  logic signed [31:0]   right_handle_x,
  input  logic signed [31:0]   right_handle_y,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output pbt_pkg::seg_cmd_t    cmd
);

  logic                have_prev_r;
  logic signed [31:0]  prev_ax_r, prev_ay_r, prev_hx_r, prev_hy_r;
  logic                accept;

  // The queue behind decides when a word can be taken.
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  // Build the control points of the segment.
  always_comb begin
    cmd.emit_self = curve_start || !have_prev_r;
    cmd.p0_x = prev_ax_r;
    cmd.p0_y = prev_ay_r;
    cmd.p1_x = prev_hx_r;
    cmd.p1_y = prev_hy_r;
    cmd.p2_x = left_handle_x;
    cmd.p2_y = left_handle_y;
    cmd.p3_x = anchor_x;
    cmd.p3_y = anchor_y;
  end

  // Keep the anchor as the start of the next segment.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_ax_r   <= '0;
      prev_ay_r   <= '0;
      prev_hx_r   <= '0;
      prev_hy_r   <= '0;
    end else if (accept) begin
      have_prev_r <= 1'b1;
      prev_ax_r   <= anchor_x;
      prev_ay_r   <= anchor_y;
      prev_hx_r   <= right_handle_x;
      prev_hy_r   <= right_handle_y;
    end
  end

endmodule

@@ hdl/pbt_queue.sv @@
// Two-entry queue between the front and back parts.
module pbt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  pbt_pkg::seg_cmd_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output pbt_pkg::seg_cmd_t rd_data
);

  pbt_pkg::seg_cmd_t mem_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // Storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> wp_r == rp_r) else $error("pointer mismatch when empty");
`endif

endmodule

@@ hdl/pbt_back.sv @@
// Back part: steps t over the segment, blends the control points, buffers points.
module pbt_back #(
  parameter int SEGMENT_POINTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  pbt_pkg::seg_cmd_t cmd,
  output logic              out_empty,
  input  logic              out_pop,
  output pbt_pkg::point_t   pt
);

  localparam int JW = $clog2(SEGMENT_POINTS + 1);

  function automatic logic [16:0] t_of(input int j);
    return 17'((j * 65536 + SEGMENT_POINTS / 2) / SEGMENT_POINTS);
  endfunction

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                 state_r;
  logic [JW-1:0]          j_r;
  logic signed [31:0]     px_r [4];
  logic signed [31:0]     py_r [4];
  logic [pbt_pkg::WeightW-1:0] w_r [4];
  logic [pbt_pkg::WeightW-1:0] wtab [SEGMENT_POINTS+1][4];
  logic signed [49:0]     prx_r [4];
  logic signed [49:0]     pry_r [4];
  logic                   mul_v_r, sum_v_r;
  logic                   last_m_r;
  pbt_pkg::point_t        res_r;
  logic                   res_v_r;
  logic                   busy;
  logic signed [pbt_pkg::AccW-1:0] sx, sy;

  // Weight table, one row per step, worked out at elaboration.
  for (genvar g = 0; g <= SEGMENT_POINTS; g++) begin : g_wrow
    for (genvar k = 0; k < 4; k++) begin : g_wcol
      localparam logic [pbt_pkg::WeightW-1:0] WVal = pbt_pkg::bern_weight(t_of(g), k);
      assign wtab[g][k] = WVal;
    end
  end

  // Saturate a rounded accumulator to 32 bits.
  function automatic logic signed [31:0] sat(input logic signed [pbt_pkg::AccW-1:0] a);
    logic signed [pbt_pkg::AccW-1:0] r;
    r = (a + pbt_pkg::AccW'(32768)) >>> 16;
    if (r > pbt_pkg::AccW'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (r < -pbt_pkg::AccW'(64'sh8000_0000)) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  assign cmd_ready = (state_r == S_IDLE) && !busy;
  assign busy      = mul_v_r || sum_v_r || res_v_r;
  assign out_empty = !res_v_r;
  assign pt        = res_r;

  // Step sequencer: one step issues weights for one point.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            j_r     <= cmd.emit_self ? JW'(SEGMENT_POINTS) : JW'(1);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!res_v_r && !sum_v_r && !mul_v_r) begin
            if (j_r == JW'(SEGMENT_POINTS)) begin
              state_r <= S_IDLE;
            end else begin
              j_r     <= j_r + JW'(1);
              state_r <= S_MUL;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Control points held for the segment.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      px_r[0] <= cmd.emit_self ? 32'sd0 : cmd.p0_x;
      px_r[1] <= cmd.emit_self ? 32'sd0 : cmd.p1_x;
      px_r[2] <= cmd.emit_self ? 32'sd0 : cmd.p2_x;
      px_r[3] <= cmd.p3_x;
      py_r[0] <= cmd.emit_self ? 32'sd0 : cmd.p0_y;
      py_r[1] <= cmd.emit_self ? 32'sd0 : cmd.p1_y;
      py_r[2] <= cmd.emit_self ? 32'sd0 : cmd.p2_y;
      py_r[3] <= cmd.p3_y;
    end
  end

  // Weights of the current step: a self-emit uses t = 1 (w3 = 1.0).
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      for (int k = 0; k < 4; k++) begin
        w_r[k] <= wtab[j_r][k];
      end
    end
  end

  // Products, then sum and round.
  always_comb begin
    sx = pbt_pkg::AccW'(prx_r[0]) + pbt_pkg::AccW'(prx_r[1])
       + pbt_pkg::AccW'(prx_r[2]) + pbt_pkg::AccW'(prx_r[3]);
    sy = pbt_pkg::AccW'(pry_r[0]) + pbt_pkg::AccW'(pry_r[1])
       + pbt_pkg::AccW'(pry_r[2]) + pbt_pkg::AccW'(pry_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      sum_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      mul_v_r <= (state_r == S_MUL);
      if (mul_v_r) begin
        last_m_r <= (j_r == JW'(SEGMENT_POINTS));
        for (int k = 0; k < 4; k++) begin
          prx_r[k] <= $signed({1'b0, w_r[k]}) * px_r[k];
          pry_r[k] <= $signed({1'b0, w_r[k]}) * py_r[k];
        end
      end
      sum_v_r <= mul_v_r;
      if (sum_v_r) begin
        res_r.x    <= sat(sx);
        res_r.y    <= sat(sy);
        res_r.last <= last_m_r;
        res_v_r    <= 1'b1;
      end else if (out_pop && res_v_r) begin
        res_v_r <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({mul_v_r, sum_v_r, res_v_r}) <= 1) else $error("overlapping points");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && !out_pop |=> res_v_r && $stable(res_r)) else $error("point lost");
`endif

endmodule

@@ hdl/poly_bezier_tessellator.sv @@
// Top level of the poly-Bezier tessellator.
//  channel | direction | handshake   | word
//  in_     | input     | push / full | one anchor with handles and curve_start
//  out_    | output    | pop / empty | one point with run_last
// Each point passes through the back part in order (weights, products, sum, output
// register, step check), and the next point starts only once the previous one is popped.
// The point pipeline is sequential through the single output register.
// Reset is synchronous, active low, and clears the previous-anchor state.
// A two-entry queue lets the front take anchors while the back is busy.
module poly_bezier_tessellator #(
  parameter int SEGMENT_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_curve_start,
  input  logic signed [31:0] in_anchor_x,
  input  logic signed [31:0] in_anchor_y,
  input  logic signed [31:0] in_left_handle_x,
  input  logic signed [31:0] in_left_handle_y,
  input  logic signed [31:0] in_right_handle_x,
  input  logic signed [31:0] in_right_handle_y,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic               out_run_last
);

  logic              f_valid, f_ready, q_valid, q_ready, in_ready;
  pbt_pkg::seg_cmd_t f_cmd, q_cmd;
  pbt_pkg::point_t   pt;

  assign full = !in_ready;

  pbt_front u_front (
    .clk, .rst_n,
    .in_valid(push), .in_ready,
    .curve_start(in_curve_start),
    .anchor_x(in_anchor_x), .anchor_y(in_anchor_y),
    .left_handle_x(in_left_handle_x), .left_handle_y(in_left_handle_y),
    .right_handle_x(in_right_handle_x), .right_handle_y(in_right_handle_y),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  pbt_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  pbt_back #(.SEGMENT_POINTS(SEGMENT_POINTS)) u_back (
    .clk, .rst_n,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_empty(empty), .out_pop(pop), .pt
  );

  assign out_point_x  = pt.x;
  assign out_point_y  = pt.y;
  assign out_run_last = pt.last;

endmodule

@@ tb/sv/poly_bezier_tessellator_checker.sv @@
// Checker that predicts the tessellated points and compares them with the block's output.
`timescale 1ns / 100ps
module poly_bezier_tessellator_checker #(
  parameter int SEGMENT_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic               in_curve_start,
  input  logic signed [31:0] in_anchor_x,
  input  logic signed [31:0] in_anchor_y,
  input  logic signed [31:0] in_left_handle_x,
  input  logic signed [31:0] in_left_handle_y,
  input  logic signed [31:0] in_right_handle_x,
  input  logic signed [31:0] in_right_handle_y,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [31:0] out_point_x,
  input  logic signed [31:0] out_point_y,
  input  logic               out_run_last,
  output int                 fail_count,
  output int                 pending_points,
  output int                 anchors_seen,
  output int                 points_seen
);

  // Shadow copy of the block's curve state.
  logic               seg_open;
  logic signed [31:0] last_ax, last_ay, last_hx, last_hy;
  pbt_pkg::point_t    point_queue[$];

  assign pending_points = point_queue.size();

  // Weight k of the cubic basis at step j, Q0.16 rounded half up.
  function automatic longint basis_weight(input int j, input int k);
    longint t, u, p;
    t = (longint'(j) * 65536 + SEGMENT_POINTS / 2) / SEGMENT_POINTS;
    u = 65536 - t;
    case (k)
      0:       p = u * u * u;
      1:       p = 3 * u * u * t;
      2:       p = 3 * u * t * t;
      default: p = t * t * t;
    endcase
    return (p + 64'h8000_0000) >>> 32;
  endfunction

  // Weighted sum of four coordinates, rounded half toward +inf and saturated.
  function automatic logic signed [31:0] mix_coord(input int j, input longint a,
                                                   input longint b, input longint c,
                                                   input longint d);
    longint acc, r;
    acc = basis_weight(j, 0) * a + basis_weight(j, 1) * b
        + basis_weight(j, 2) * c + basis_weight(j, 3) * d;
    r = (acc + 32768) >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  always @(posedge clk) begin
    pbt_pkg::point_t p, want;
    if (!rst_n) begin
      seg_open <= 1'b0;
      last_ax <= '0;
      last_ay <= '0;
      last_hx <= '0;
      last_hy <= '0;
      point_queue.delete();
      fail_count <= 0;
      anchors_seen <= 0;
      points_seen <= 0;
    end else begin
      // Compare an accepted point with the oldest expected one.
      if (pop && !empty) begin
        points_seen <= points_seen + 1;
        if (point_queue.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
                   out_point_x, out_point_y, out_run_last);
          fail_count <= fail_count + 1;
        end else begin
          want = point_queue.pop_front();
          if (want.x !== out_point_x || want.y !== out_point_y ||
              want.last !== out_run_last) begin
            $display("%0t: point mismatch expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $time, want.x, want.y, want.last, out_point_x, out_point_y,
                     out_run_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Expand an accepted anchor into its expected points.
      if (push && !full) begin
        anchors_seen <= anchors_seen + 1;
        if (in_curve_start || !seg_open) begin
          p.x = in_anchor_x;
          p.y = in_anchor_y;
          p.last = 1'b1;
          point_queue.push_back(p);
        end else begin
          for (int j = 1; j <= SEGMENT_POINTS; j++) begin
            p.x = mix_coord(j, last_ax, last_hx, in_left_handle_x, in_anchor_x);
            p.y = mix_coord(j, last_ay, last_hy, in_left_handle_y, in_anchor_y);
            p.last = (j == SEGMENT_POINTS);
            point_queue.push_back(p);
          end
        end
        seg_open <= 1'b1;
        last_ax <= in_anchor_x;
        last_ay <= in_anchor_y;
        last_hx <= in_right_handle_x;
        last_hy <= in_right_handle_y;
      end
    end
  end
endmodule

@@ tb/sv/poly_bezier_tessellator_tb.sv @@
// Testbench top: drives anchors into the tessellator and gives the verdict.
`timescale 1ns / 100ps
module poly_bezier_tessellator_tb;
  localparam int SegPoints    = 16;
  localparam int RandomItems  = 480;
  localparam int StallLimit   = 20000;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic               in_curve_start;
  logic signed [31:0] in_anchor_x, in_anchor_y;
  logic signed [31:0] in_left_handle_x, in_left_handle_y;
  logic signed [31:0] in_right_handle_x, in_right_handle_y;
  logic               empty;
  logic               pop;
  logic signed [31:0] out_point_x, out_point_y;
  logic               out_run_last;
  int                 fail_count, pending_points, anchors_seen, points_seen;
  int                 idle_cycles;
  bit                 hold_pop;

  poly_bezier_tessellator #(.SEGMENT_POINTS(SegPoints)) u_top (
    .clk, .rst_n, .push, .full, .in_curve_start, .in_anchor_x, .in_anchor_y,
    .in_left_handle_x, .in_left_handle_y, .in_right_handle_x, .in_right_handle_y,
    .empty, .pop, .out_point_x, .out_point_y, .out_run_last
  );

  poly_bezier_tessellator_checker #(.SEGMENT_POINTS(SegPoints)) u_checker (
    .clk, .rst_n, .push, .full, .in_curve_start, .in_anchor_x, .in_anchor_y,
    .in_left_handle_x, .in_left_handle_y, .in_right_handle_x, .in_right_handle_y,
    .empty, .pop, .out_point_x, .out_point_y, .out_run_last,
    .fail_count, .pending_points, .anchors_seen, .points_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Coordinate mix: extremes, small values near zero, or full random.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3, 4: return $signed($urandom_range(0, 200000)) - 100000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one anchor and hold it until it is taken; push stays high for a
  // following anchor with no gap.
  task automatic send_anchor(input logic start, input logic signed [31:0] ax,
                             input logic signed [31:0] ay, input logic signed [31:0] lx,
                             input logic signed [31:0] ly, input logic signed [31:0] rx,
                             input logic signed [31:0] ry, input bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    in_curve_start <= start;
    in_anchor_x <= ax;
    in_anchor_y <= ay;
    in_left_handle_x <= lx;
    in_left_handle_y <= ly;
    in_right_handle_x <= rx;
    in_right_handle_y <= ry;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Receiver: random pops, with one long hold-off on request.
  initial begin
    int g;
    pop = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_pop) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        hold_pop = 1'b0;
      end
      g = (points_seen / 300) % 2 == 1 ? 0 : gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    rst_n = 1'b0;
    push = 1'b0;
    hold_pop = 1'b0;
    in_curve_start = 1'b0;
    {in_anchor_x, in_anchor_y, in_left_handle_x, in_left_handle_y} = '0;
    {in_right_handle_x, in_right_handle_y} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first anchor without a start flag after reset emits itself.
    send_anchor(1'b0, 32'sd256, -32'sd512, 32'sd7, 32'sd9, 32'sd1000, 32'sd2000, 1'b0);
    send_anchor(1'b0, 32'sd4096, 32'sd4096, 32'sd3000, -32'sd100, 32'sd5000, 32'sd5000, 1'b0);
    // Curve start ignores its left handle.
    send_anchor(1'b1, 32'sd0, 32'sd0, mx, mn, 32'sd0, 32'sd0, 1'b0);
    // Extreme control points to drive saturation both ways.
    send_anchor(1'b0, mx, mx, mx, mx, mn, mn, 1'b0);
    send_anchor(1'b0, mx, mn, mn, mx, mx, mx, 1'b0);
    send_anchor(1'b0, mn, mn, mn, mn, mn, mn, 1'b0);
    send_anchor(1'b1, mx, mx, 32'sd0, 32'sd0, mx, mx, 1'b0);
    send_anchor(1'b0, mx, mx, mx, mx, 32'sd0, 32'sd0, 1'b0);
    send_anchor(1'b0, -32'sd1, 32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1, 1'b0);
    send_anchor(1'b1, mn, mx, mx, mn, mn, mx, 1'b0);
    send_anchor(1'b0, mx, mn, mn, mx, mx, mn, 1'b0);

    // Long receiver hold-off while anchors keep coming.
    hold_pop = 1'b1;
    for (int i = 0; i < 8; i++)
      send_anchor(i == 0, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), 1'b1);
    push <= 1'b0;
    // Sender pauses until every point has come back.
    while (pending_points != 0) @(posedge clk);

    // Random curves: mostly continuations, with a start now and then.
    for (int i = 0; i < RandomItems; i++)
      send_anchor($urandom_range(0, 9) == 0, pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), pick_coord(), (i / 60) % 3 == 2);
    push <= 1'b0;

    while (pending_points != 0) @(posedge clk);
    repeat (4 * SegPoints + 20) @(posedge clk);

    $display("Run covered %0d anchors and %0d points, including saturating extremes,",
             anchors_seen, points_seen);
    $display("curve starts, a first anchor without start, and a long output stall.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
